// ===== hw/rtl/plml_pkg.sv =====
`timescale 1ns / 1ps
package plml_pkg;
   localparam int MAX_POINTS = 1024;
   localparam int ADDR_W     = 10;
   localparam int CNT_W      = 11;
   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_ORDER  = 2'd1;
   localparam logic [1:0] ST_RANGE  = 2'd2;
   localparam logic [1:0] ST_SAT    = 2'd3;

   localparam logic [DATA_W-1:0] RESET_POS1 = 32'd1000000;
   localparam logic [DATA_W-1:0] RESET_GEN1 = 32'd65536;

   typedef logic [DATA_W-1:0] word_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [1:0]        status_type;
endpackage

// ===== hw/rtl/plml_req_if.sv =====
`timescale 1ns / 1ps
interface plml_req_if;
   import plml_pkg::*;
   logic     valid;
   logic     ready;
   logic     cmd;
   addr_type entry_index;
   word_type base_position;
   word_type genetic_value;
   modport source (output valid, cmd, entry_index, base_position, genetic_value, input ready);
   modport sink (input valid, cmd, entry_index, base_position, genetic_value, output ready);
endinterface

// ===== hw/rtl/plml_rsp_if.sv =====
`timescale 1ns / 1ps
interface plml_rsp_if;
   import plml_pkg::*;
   logic       valid;
   logic       ready;
   word_type   genetic_result;
   status_type status;
   modport source (output valid, genetic_result, status, input ready);
   modport sink (input valid, genetic_result, status, output ready);
endinterface

// ===== hw/rtl/plml_csr_if.sv =====
`timescale 1ns / 1ps
interface plml_csr_if;
   import plml_pkg::*;
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/plml_mult.sv =====
`timescale 1ns / 1ps
module plml_mult (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [plml_pkg::DATA_W-1:0]    mcand,
   input  logic [plml_pkg::DATA_W-1:0]    mplier,
   output logic                           done,
   output logic [plml_pkg::PROD_W-1:0]    product
);
   import plml_pkg::*;

   localparam int STEP_W = $clog2(DATA_W);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [DATA_W-1:0]    mcand_ff, mcand_in;
   logic [DATA_W:0]      sum;

   // one multiplier bit per cycle, shift-add into the upper half
   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      sum      = {1'b0, prod_ff[PROD_W-1:DATA_W]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      if (start) begin
         run_in   = 1'b1;
         cnt_in   = '0;
         prod_in  = {{DATA_W{1'b0}}, mplier};
         mcand_in = mcand;
      end else if (run_ff) begin
         prod_in = {sum, prod_ff[DATA_W-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(DATA_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;
endmodule

// ===== hw/rtl/plml_div.sv =====
`timescale 1ns / 1ps
module plml_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [plml_pkg::PROD_W-1:0]    dividend,
   input  logic [plml_pkg::DATA_W-1:0]    divisor,
   output logic                           done,
   output logic [plml_pkg::PROD_W-1:0]    quotient
);
   import plml_pkg::*;

   localparam int STEP_W = $clog2(PROD_W);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic [PROD_W-1:0]    dvd_ff, dvd_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    den_ff, den_in;
   logic [DATA_W:0]      rem_sh;
   logic [DATA_W:0]      rem_sub;

   // restoring division, one quotient bit per cycle shifted into the dividend
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff, dvd_ff[PROD_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (run_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sub[DATA_W-1:0];
            dvd_in = {dvd_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DATA_W-1:0];
            dvd_in = {dvd_ff[PROD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(PROD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;
endmodule

// ===== hw/rtl/piecewise_linear_map_lookup_core.sv =====
`timescale 1ns / 1ps
// a load is checked and written in S_LDCHK, and its response is registered once the response slot is free
// a query runs a binary search of table probes (S_SRCH, S_SCMP) over the n points in use, fetches the
// segment ends (S_F1, S_F2), runs a shift-add multiply and a restoring divide, then registers its response;
// a zero-length segment skips multiply and divide
// throughput: one request at a time, the next is taken the cycle after a response is registered
// reset: a clearing pass over all 1024 table entries rebuilds the default two-point table, no requests taken
module piecewise_linear_map_lookup_core (
   input  logic        clock,
   input  logic        reset,
   plml_req_if.sink    req_if,
   plml_rsp_if.source  rsp_if,
   plml_csr_if.sink    csr_if
);
   import plml_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_LDCHK = 4'd2;
   localparam logic [3:0] S_SRCH  = 4'd3;
   localparam logic [3:0] S_SCMP  = 4'd4;
   localparam logic [3:0] S_F1    = 4'd5;
   localparam logic [3:0] S_F2    = 4'd6;
   localparam logic [3:0] S_PREP  = 4'd7;
   localparam logic [3:0] S_MST   = 4'd8;
   localparam logic [3:0] S_MUL   = 4'd9;
   localparam logic [3:0] S_DIV   = 4'd10;
   localparam logic [3:0] S_FIN   = 4'd11;

   word_type pos_mem [MAX_POINTS];
   word_type gen_mem [MAX_POINTS];

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff;
   addr_type          clr_ff, clr_in;
   addr_type          lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   addr_type          idx_ff;
   word_type          bp_ff, gv_ff;
   word_type          p1_ff, p1_in, g1_ff, g1_in, p2_ff, p2_in, g2_ff, g2_in;
   word_type          dg_ff, dx_ff, den_ff;
   logic              neg_ff, zero_seg_ff, zero_seg_in;
   word_type          pos_rd_ff, gen_rd_ff;
   addr_type          rd_addr;
   logic              wr_en;
   addr_type          wr_addr;
   word_type          wr_pos, wr_gen;
   logic              rsp_valid_ff, rsp_valid_in;
   word_type          rsp_res_ff, rsp_res_in;
   status_type        rsp_st_ff, rsp_st_in;
   logic              slot_free;
   logic [CNT_W-1:0]  n_used;
   addr_type          mid_calc;
   logic              mul_start, mul_done, div_start, div_done;
   logic [PROD_W-1:0] product, quotient, q_sel;
   logic              q_wide;
   logic [DATA_W+1:0] q_low, lo_limit;
   logic [DATA_W+2:0] diff;
   logic [DATA_W:0]   pos_sum;
   word_type          fin_res;
   status_type        fin_st;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = (state_ff == S_IDLE);
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      if (count_ff < CNT_W'(2))               n_used = CNT_W'(2);
      else if (count_ff > CNT_W'(MAX_POINTS)) n_used = CNT_W'(MAX_POINTS);
      else                                    n_used = count_ff;
   end

   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);

   // result of the segment formula with saturation
   always_comb begin
      q_sel    = zero_seg_ff ? '0 : quotient;
      q_wide   = (q_sel[PROD_W-1:DATA_W+2] != '0);
      q_low    = q_sel[DATA_W+1:0];
      lo_limit = {2'b00, g1_ff} + (DATA_W+2)'(33'h080000000);
      pos_sum  = {1'b0, g1_ff} + {1'b0, q_sel[DATA_W-1:0]};
      diff     = {3'b000, g1_ff} - {1'b0, q_low};
      fin_res  = '0;
      fin_st   = ST_OK;
      if (!neg_ff || zero_seg_ff || q_sel == '0) begin
         if (q_sel[PROD_W-1:DATA_W-1] != '0 || pos_sum[DATA_W:DATA_W-1] != 2'b00) begin
            fin_res = 32'h7FFFFFFF;
            fin_st  = ST_SAT;
         end else begin
            fin_res = pos_sum[DATA_W-1:0];
         end
      end else if (q_wide || q_low > lo_limit) begin
         fin_res = 32'h80000000;
         fin_st  = ST_SAT;
      end else if (!diff[DATA_W+2] && diff[DATA_W+1:DATA_W-1] != 3'b000) begin
         fin_res = 32'h7FFFFFFF;
         fin_st  = ST_SAT;
      end else begin
         fin_res = diff[DATA_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      p1_in        = p1_ff;
      g1_in        = g1_ff;
      p2_in        = p2_ff;
      g2_in        = g2_ff;
      zero_seg_in  = zero_seg_ff;
      rd_addr      = lo_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_pos       = bp_ff;
      wr_gen       = gv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_res_in   = rsp_res_ff;
      rsp_st_in    = rsp_st_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_pos  = (clr_ff == addr_type'(1)) ? RESET_POS1 : '0;
            wr_gen  = (clr_ff == addr_type'(1)) ? RESET_GEN1 : '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == addr_type'(MAX_POINTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            rd_addr = req_if.entry_index - 1'b1;
            if (req_if.valid) begin
               if (req_if.cmd == CMD_LOAD) begin
                  state_in = S_LDCHK;
               end else begin
                  lo_in    = '0;
                  hi_in    = addr_type'(n_used - 1'b1);
                  state_in = S_SRCH;
               end
            end
         end
         S_LDCHK: begin
            // keep the previous slot on the read port while the response slot is busy
            rd_addr = idx_ff - 1'b1;
            if (slot_free) begin
               wr_en        = ({1'b0, idx_ff} < CNT_W'(MAX_POINTS));
               rsp_valid_in = 1'b1;
               rsp_res_in   = '0;
               if (!wr_en)
                  rsp_st_in = ST_RANGE;
               else if (idx_ff != '0 && (bp_ff < pos_rd_ff || gv_ff < gen_rd_ff))
                  rsp_st_in = ST_ORDER;
               else
                  rsp_st_in = ST_OK;
               state_in = S_IDLE;
            end
         end
         S_SRCH: begin
            if ((hi_ff - lo_ff) > addr_type'(1)) begin
               rd_addr  = mid_calc;
               mid_in   = mid_calc;
               state_in = S_SCMP;
            end else begin
               rd_addr  = lo_ff;
               state_in = S_F1;
            end
         end
         S_SCMP: begin
            if (bp_ff < pos_rd_ff) hi_in = mid_ff;
            else                   lo_in = mid_ff;
            state_in = S_SRCH;
         end
         S_F1: begin
            p1_in    = pos_rd_ff;
            g1_in    = gen_rd_ff;
            rd_addr  = lo_ff + 1'b1;
            state_in = S_F2;
         end
         S_F2: begin
            p2_in    = pos_rd_ff;
            g2_in    = gen_rd_ff;
            state_in = S_PREP;
         end
         S_PREP: begin
            zero_seg_in = (p1_ff == p2_ff);
            state_in    = (p1_ff == p2_ff) ? S_FIN : S_MST;
         end
         S_MST: begin
            mul_start = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) state_in = S_FIN;
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = fin_res;
               rsp_st_in    = fin_st;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pos_mem[wr_addr] <= wr_pos;
         gen_mem[wr_addr] <= wr_gen;
      end
      pos_rd_ff <= pos_mem[rd_addr];
      gen_rd_ff <= gen_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= CNT_W'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid) count_ff <= csr_if.data;
      end
      if (req_if.valid && req_if.ready) begin
         idx_ff <= req_if.entry_index;
         bp_ff  <= req_if.base_position;
         gv_ff  <= req_if.genetic_value;
      end
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      p1_ff       <= p1_in;
      g1_ff       <= g1_in;
      p2_ff       <= p2_in;
      g2_ff       <= g2_in;
      zero_seg_ff <= zero_seg_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_st_ff   <= rsp_st_in;
      // magnitudes and sign of the slope terms
      if (state_ff == S_PREP) begin
         dg_ff  <= (g2_ff >= g1_ff) ? g2_ff - g1_ff : g1_ff - g2_ff;
         dx_ff  <= (bp_ff >= p1_ff) ? bp_ff - p1_ff : p1_ff - bp_ff;
         den_ff <= (p2_ff >= p1_ff) ? p2_ff - p1_ff : p1_ff - p2_ff;
         neg_ff <= ((g2_ff < g1_ff) != (bp_ff < p1_ff)) != (p2_ff < p1_ff);
      end
   end

   plml_mult u_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (dg_ff),
      .mplier  (dx_ff),
      .done    (mul_done),
      .product (product)
   );

   plml_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.genetic_result = rsp_res_ff;
   assign rsp_if.status         = rsp_st_ff;
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import plml_pkg::*;

   typedef struct {
      word_type   genetic_result;
      status_type status;
   } map_result_type;

   class map_scoreboard;
      word_type    pos_tab [MAX_POINTS];
      word_type    gen_tab [MAX_POINTS];
      logic [CNT_W-1:0] point_count;
      map_result_type pending [$];
      int          errors;
      int          checked;
      int          n_sat;
      int          n_order;

      function new();
         foreach (pos_tab[i]) begin
            pos_tab[i] = '0;
            gen_tab[i] = '0;
         end
         pos_tab[1]  = RESET_POS1;
         gen_tab[1]  = RESET_GEN1;
         point_count = 2;
         errors      = 0;
         checked     = 0;
         n_sat       = 0;
         n_order     = 0;
      endfunction

      function int points_in_use();
         int n;
         n = point_count;
         if (n < 2) n = 2;
         if (n > MAX_POINTS) n = MAX_POINTS;
         return n;
      endfunction

      function map_result_type interpolate(word_type bp);
         map_result_type r;
         int lo, hi, mid;
         word_type p1, p2, g1, g2;
         logic [63:0] dg, dx, den, q;
         logic [64:0] sum;
         bit neg, sat_hi, sat_lo;
         longint res;
         lo = 0;
         hi = points_in_use() - 1;
         while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (bp < pos_tab[mid]) hi = mid;
            else lo = mid;
         end
         p1 = pos_tab[lo];
         p2 = pos_tab[lo+1];
         g1 = gen_tab[lo];
         g2 = gen_tab[lo+1];
         q = 0;
         neg = 0;
         sat_hi = 0;
         sat_lo = 0;
         res = 0;
         if (p1 != p2) begin
            dg  = (g2 >= g1) ? 64'(g2 - g1) : 64'(g1 - g2);
            dx  = (bp >= p1) ? 64'(bp - p1) : 64'(p1 - bp);
            den = (p2 >= p1) ? 64'(p2 - p1) : 64'(p1 - p2);
            neg = ((g2 < g1) != (bp < p1)) != (p2 < p1);
            q   = (dg * dx) / den;
            if (q == 0) neg = 0;
         end
         if (!neg) begin
            sum = 65'(g1) + 65'(q);
            if (q > 64'h7FFF_FFFF || sum > 65'h7FFF_FFFF) sat_hi = 1;
            else res = longint'(sum);
         end else begin
            if (q > 64'(g1) + 64'h8000_0000) sat_lo = 1;
            else begin
               res = longint'(64'(g1)) - longint'(q);
               if (res > 64'sh7FFF_FFFF) sat_hi = 1;
            end
         end
         r.status = ST_OK;
         if (sat_hi) begin
            res = 64'sh7FFF_FFFF;
            r.status = ST_SAT;
         end
         if (sat_lo) begin
            res = -64'sh8000_0000;
            r.status = ST_SAT;
         end
         r.genetic_result = res[31:0];
         return r;
      endfunction

      function void note_request(logic cmd, addr_type idx, word_type bp, word_type gv);
         map_result_type r;
         if (cmd == CMD_LOAD) begin
            r.genetic_result = '0;
            r.status = ST_OK;
            pos_tab[idx] = bp;
            gen_tab[idx] = gv;
            if (idx > 0 && (bp < pos_tab[idx-1] || gv < gen_tab[idx-1])) begin
               r.status = ST_ORDER;
               n_order++;
            end
         end else begin
            r = interpolate(bp);
            if (r.status == ST_SAT) n_sat++;
         end
         pending = {pending, r};
      endfunction

      task report(string what);
         errors++;
         if (errors <= 20) $display("mismatch at %0t: %s", $realtime, what);
      endtask

      task check_response(word_type res, status_type st);
         map_result_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected response %h/%0d", res, st));
            return;
         end
         e = pending.pop_front();
         checked++;
         if (res !== e.genetic_result)
            report($sformatf("genetic_result %h, want %h", res, e.genetic_result));
         if (st !== e.status)
            report($sformatf("status %0d, want %0d", st, e.status));
      endtask
   endclass

   logic clock;
   logic reset;
   plml_req_if req_bus ();
   plml_rsp_if rsp_bus ();
   plml_csr_if csr_bus ();

   piecewise_linear_map_lookup_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   map_scoreboard sb;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_off;
   bit  hold_trigger;
   int  items_sent;
   int  cfg_writes;
   longint cycles;

   localparam longint CYCLE_LIMIT = 2_000_000;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_LOAD;
      req_bus.entry_index = '0;
      req_bus.base_position = '0;
      req_bus.genetic_value = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      send_idle_pct = 12;
      recv_stall_pct = 73;
      hold_off = 1'b0;
      hold_trigger = 1'b0;
      items_sent = 0;
      cfg_writes = 0;
      cycles = 0;
      sb = new();
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      if (rsp_bus.valid && rsp_bus.ready)
         sb.check_response(rsp_bus.genetic_result, rsp_bus.status);
   end

   // long receiver hold-off so the block backs up into the request side
   initial begin
      wait (hold_trigger);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (600) @(posedge clock);
      hold_off = 1'b0;
   end

   task send_request(logic cmd, addr_type idx, word_type bp, word_type gv);
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.entry_index <= idx;
      req_bus.base_position <= bp;
      req_bus.genetic_value <= gv;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(cmd, idx, bp, gv);
      items_sent++;
      if (items_sent < 550) begin
         send_idle_pct = 12;
         recv_stall_pct = 73;
      end else if (items_sent < 1100) begin
         send_idle_pct = 73;
         recv_stall_pct = 12;
      end else begin
         send_idle_pct = 0;
         recv_stall_pct = 0;
      end
      if (items_sent == 300) hold_trigger = 1'b1;
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task load_point(addr_type idx, word_type bp, word_type gv);
      send_request(CMD_LOAD, idx, bp, gv);
   endtask

   task query_point(word_type bp);
      send_request(CMD_QUERY, addr_type'($urandom_range(0, 1023)), bp, $urandom);
   endtask

   task wait_drained();
      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task write_point_count(logic [CNT_W-1:0] value);
      wait_drained();
      csr_bus.valid <= 1'b1;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sb.point_count = value;
      cfg_writes++;
      @(posedge clock);
   endtask

   task random_phase();
      int n;
      int sel;
      int nq;
      word_type base, step, bp, gv, gstep;
      sel = $urandom_range(99);
      if (sel < 80) n = $urandom_range(2, 16);
      else if (sel < 90) n = $urandom_range(17, 40);
      else case ($urandom_range(3))
         0: n = 0;
         1: n = 1;
         2: n = 2047;
         default: n = 1024;
      endcase
      write_point_count(CNT_W'(n));
      if (n < 2) n = 2;
      if (n > 40) n = $urandom_range(2, 40);
      base  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 100000);
      step  = $urandom >> $urandom_range(0, 31);
      gstep = $urandom >> $urandom_range(4, 31);
      bp = base;
      gv = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
      for (int i = 0; i < n; i++) begin
         // mostly sorted tables, now and then an out-of-order point
         if ($urandom_range(19) == 0) load_point(addr_type'(i), $urandom, $urandom);
         else load_point(addr_type'(i), bp, gv);
         bp = bp + $urandom_range(0, step);
         if ($urandom_range(9) == 0) gv = gv - $urandom_range(0, gstep);
         else gv = gv + $urandom_range(0, gstep);
      end
      nq = $urandom_range(8, 20);
      for (int i = 0; i < nq; i++) begin
         sel = $urandom_range(9);
         if (sel < 6) query_point(base + $urandom_range(0, step * n));
         else if (sel < 8) query_point($urandom);
         else load_point(addr_type'($urandom_range(0, 1023)), $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default two-point table, in range and far beyond the right end
      query_point(32'd0);
      query_point(32'd500000);
      query_point(32'hFFFF_FFFF);
      load_point(10'd0, 32'd100, 32'd100);
      load_point(10'd1, 32'd50, 32'd200);
      load_point(10'd1, 32'd200, 32'd50);
      // zero-length segment
      load_point(10'd1, 32'd100, 32'd300);
      query_point(32'd100);
      load_point(10'd0, 32'd100, 32'hFFFF_FFFF);
      query_point(32'd7);
      // extrapolation to the left, down to and below the negative bound
      load_point(10'd0, 32'd1000, 32'd0);
      load_point(10'd1, 32'd2000, 32'h8000_0000);
      query_point(32'd0);
      load_point(10'd1, 32'd2000, 32'hFFFF_FFFF);
      query_point(32'd0);
      query_point(32'd1500);
      load_point(10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      load_point(10'd2, 32'd3000, 32'd5);
      write_point_count(11'd1024);
      query_point(32'hFFFF_FFFF);
      query_point(32'd2500);
      write_point_count(11'd2047);
      query_point(32'd1);
      write_point_count(11'd0);
      query_point(32'd1999);
      write_point_count(11'd1);
      query_point(32'h8000_0000);

      while (items_sent < 1550) random_phase();

      wait_drained();
      repeat (300) @(posedge clock);
      $display("covered %0d requests, %0d responses, %0d point_count writes",
               items_sent, sb.checked, cfg_writes);
      $display("saturated queries %0d, out-of-order loads %0d", sb.n_sat, sb.n_order);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
hw/rtl/plml_pkg.sv
hw/rtl/plml_req_if.sv
hw/rtl/plml_rsp_if.sv
hw/rtl/plml_csr_if.sv
hw/rtl/plml_mult.sv
hw/rtl/plml_div.sv
hw/rtl/piecewise_linear_map_lookup_core.sv
tb/sv/tb_top.sv
